[design/dlf_pkg.sv]
// dlf_pkg: shared constants, register indexes and stage payload types
// for the distance light falloff pipeline; no dependencies
package dlf_pkg;

    localparam logic [7:0]  LVL_MAX     = 8'd255;
    localparam logic [16:0] BRIGHT_FULL = 17'd65280;
    localparam logic [15:0] DIV5_RECIP  = 16'd52429;
    localparam logic [11:0] COEF_BASE   = 12'd4080;
    localparam logic [11:0] COEF_STEP   = 12'd13;
    localparam logic [28:0] DIV255      = 29'd255;

    localparam int SQ_STAGES  = 8;
    localparam int SQ_STEPS   = 2;
    localparam int DIV_STAGES = 2;
    localparam int DIV_STEPS  = 8;

    typedef enum logic [0:0] {
        REG_FULL_SCALE = 1'b0,
        REG_MIN_MUL    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [16:0] rem;
        logic [15:0] root;
        logic [31:0] rad;
        logic [7:0]  lvl;
        logic [15:0] lo;
    } sq_t;

    typedef struct packed {
        logic [7:0]  rem;
        logic [15:0] quo;
        logic [15:0] num;
        logic        sat;
    } dv_t;

endpackage

[design/dlf_front.sv]
// dlf_front: first stage, level saturation, distance offset and floor
// depends on dlf_pkg
module dlf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [15:0]      light_level,
    input  logic [23:0]      view_distance,
    output logic             out_valid,
    input  logic             out_ready,
    output dlf_pkg::sq_t     out_data
);

    logic          valid_reg;
    dlf_pkg::sq_t  data_reg;
    dlf_pkg::sq_t  data_next;
    logic [7:0]    lvl;
    logic [23:0]   off;
    logic [23:0]   x;
    logic [23:0]   lo_prod;

    always_comb
    begin
        lvl = (light_level > {8'd0, dlf_pkg::LVL_MAX}) ? dlf_pkg::LVL_MAX : light_level[7:0];
        off = {16'd0, lvl} + {23'd0, lvl[7]};
        x = (view_distance > off) ? (view_distance - off) : 24'd0;
        lo_prod = 24'({16'd0, lvl} * {8'd0, dlf_pkg::DIV5_RECIP});
        data_next.rem  = '0;
        data_next.root = '0;
        data_next.rad  = {x, 8'd0};
        data_next.lvl  = lvl;
        data_next.lo   = {2'd0, lo_prod[23:10]};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[design/dlf_sqrt_stage.sv]
// dlf_sqrt_stage: one stage of the digit-by-digit square root,
// a few result bits per stage; depends on dlf_pkg
module dlf_sqrt_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dlf_pkg::sq_t     in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output dlf_pkg::sq_t     out_data
);

    logic          valid_reg;
    dlf_pkg::sq_t  data_reg;
    dlf_pkg::sq_t  data_next;

    always_comb
    begin
        logic [18:0] rem_w;
        logic [18:0] trial;
        data_next = in_data;
        for (int i = 0; i < dlf_pkg::SQ_STEPS; i++)
        begin
            rem_w = {data_next.rem, data_next.rad[31:30]};
            trial = {1'b0, data_next.root, 2'b01};
            if (rem_w >= trial)
            begin
                data_next.rem  = 17'(rem_w - trial);
                data_next.root = {data_next.root[14:0], 1'b1};
            end
            else
            begin
                data_next.rem  = rem_w[16:0];
                data_next.root = {data_next.root[14:0], 1'b0};
            end
            data_next.rad = {data_next.rad[29:0], 2'b00};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[design/dlf_scale.sv]
// dlf_scale: falloff multiply, divide by 255 and brightness clamp,
// four register stages; depends on dlf_pkg
module dlf_scale (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dlf_pkg::sq_t     in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      bright
);

    // stage a: product
    logic        a_valid_reg;
    logic [27:0] a_prod_reg;
    logic [7:0]  a_lvl_reg;
    logic [15:0] a_lo_reg;
    logic        a_ready;
    // stage b: quotient estimate
    logic        b_valid_reg;
    logic [27:0] b_prod_reg;
    logic [20:0] b_quo_reg;
    logic [7:0]  b_lvl_reg;
    logic [15:0] b_lo_reg;
    logic        b_ready;
    // stage c: corrected dim
    logic        c_valid_reg;
    logic [20:0] c_dim_reg;
    logic [7:0]  c_lvl_reg;
    logic [15:0] c_lo_reg;
    logic        c_ready;
    // stage d: clamped brightness
    logic        d_valid_reg;
    logic [15:0] d_bright_reg;
    logic [15:0] d_lo_reg;
    logic [15:0] d_hi_reg;
    logic        d_ready;

    logic [11:0] coef;
    logic [27:0] a_prod_next;
    logic [28:0] sum;
    logic [20:0] b_quo_next;
    logic [28:0] rem;
    logic [20:0] c_dim_next;
    logic [16:0] lim;
    logic [15:0] hi;
    logic [15:0] d_bright_next;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        coef = dlf_pkg::COEF_BASE - 12'(dlf_pkg::COEF_STEP * {4'd0, in_data.lvl});
        a_prod_next = {12'd0, in_data.root} * {16'd0, coef};

        sum = {1'b0, a_prod_reg} + {9'd0, a_prod_reg[27:8]}
            + {17'd0, a_prod_reg[27:16]} + {25'd0, a_prod_reg[27:24]};
        b_quo_next = sum[28:8];

        rem = {1'b0, b_prod_reg} - ({b_quo_reg, 8'd0} - {8'd0, b_quo_reg});
        c_dim_next = (rem >= dlf_pkg::DIV255) ? (b_quo_reg + 21'd1) : b_quo_reg;

        lim = dlf_pkg::BRIGHT_FULL - {1'b0, c_lo_reg};
        hi  = {c_lvl_reg, 8'd0};
        if (c_dim_reg >= {4'd0, lim})
        begin
            d_bright_next = c_lo_reg;
        end
        else
        begin
            d_bright_next = 16'(dlf_pkg::BRIGHT_FULL - {1'b0, c_dim_reg[15:0]});
        end
        if (d_bright_next > hi)
        begin
            d_bright_next = hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_prod_reg <= a_prod_next;
            a_lvl_reg  <= in_data.lvl;
            a_lo_reg   <= in_data.lo;
        end
        if (b_ready && a_valid_reg)
        begin
            b_prod_reg <= a_prod_reg;
            b_quo_reg  <= b_quo_next;
            b_lvl_reg  <= a_lvl_reg;
            b_lo_reg   <= a_lo_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            c_dim_reg <= c_dim_next;
            c_lvl_reg <= b_lvl_reg;
            c_lo_reg  <= b_lo_reg;
        end
        if (d_ready && c_valid_reg)
        begin
            d_bright_reg <= d_bright_next;
            d_lo_reg     <= c_lo_reg;
            d_hi_reg     <= hi;
        end
    end

    assign out_valid = d_valid_reg;
    assign bright    = d_bright_reg;

    // estimate never overshoots, so the remainder stays below two divisors
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (rem < (dlf_pkg::DIV255 + dlf_pkg::DIV255)))
        else $error("divide by 255 correction out of range");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg |-> (d_bright_reg >= d_lo_reg) && (d_bright_reg <= d_hi_reg))
        else $error("brightness outside floor and level");

endmodule

[design/dlf_div_stage.sv]
// dlf_div_stage: one stage of the restoring divider by the full scale
// register, several quotient bits per stage; depends on dlf_pkg
module dlf_div_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       full_scale,
    input  logic             in_valid,
    output logic             in_ready,
    input  dlf_pkg::dv_t     in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output dlf_pkg::dv_t     out_data
);

    logic          valid_reg;
    dlf_pkg::dv_t  data_reg;
    dlf_pkg::dv_t  data_next;

    always_comb
    begin
        logic [8:0] part;
        data_next = in_data;
        for (int i = 0; i < dlf_pkg::DIV_STEPS; i++)
        begin
            part = {data_next.rem, data_next.num[15]};
            if (part >= {1'b0, full_scale})
            begin
                data_next.rem = 8'(part - {1'b0, full_scale});
                data_next.quo = {data_next.quo[14:0], 1'b1};
            end
            else
            begin
                data_next.rem = part[7:0];
                data_next.quo = {data_next.quo[14:0], 1'b0};
            end
            data_next.num = {data_next.num[14:0], 1'b0};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[design/distance_light_falloff.sv]
// distance_light_falloff: top level, config registers, pipeline wiring
// and output register; depends on dlf_pkg and all dlf_* stage modules
//
// Usage: a request carries light_level and view_distance and is taken at a
// rising edge with req_valid high and req_stall low. Each request gives one
// light_mul (unsigned Q1.15) on the response channel, taken at an edge with
// rsp_valid high and rsp_stall low. Responses leave in request order.
// There are 16 register stages: one front stage, eight square root stages
// of two result bits each, four stages of multiply, divide by 255 and
// clamp, two divider stages of eight quotient bits each and the output
// register. Throughput is one request per cycle unless the receiver stalls.
// When the receiver stalls, the output holds and each stage keeps its item
// until the one below it frees up; bubbles close up, so requests are still
// taken until every stage is full, and nothing is lost or repeated.
// The APB port holds light_full_scale at address 0 and the minimum
// multiplier at address 4; write them only while no request is in flight.
// Reset empties the pipeline and loads full scale 255 and minimum 0.
module distance_light_falloff (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [15:0] light_level,
    input  logic [23:0] view_distance,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [15:0] light_mul
);

    logic [7:0]  full_scale_reg;
    logic [15:0] min_mul_reg;
    logic [7:0]  full_scale;

    logic          sq_valid [0:dlf_pkg::SQ_STAGES];
    logic          sq_ready [0:dlf_pkg::SQ_STAGES + 1];
    dlf_pkg::sq_t  sq_data  [0:dlf_pkg::SQ_STAGES];

    logic          sc_valid;
    logic          sc_ready;
    logic [15:0]   bright;

    logic          dv_valid [0:dlf_pkg::DIV_STAGES];
    logic          dv_ready [0:dlf_pkg::DIV_STAGES];
    dlf_pkg::dv_t  dv_data  [0:dlf_pkg::DIV_STAGES];

    logic          out_valid_reg;
    logic [15:0]   out_mul_reg;
    logic [15:0]   out_mul_next;
    logic          out_ready;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= dlf_pkg::LVL_MAX;
            min_mul_reg    <= 16'd0;
        end
        else if (psel && penable && pwrite)
        begin
            case (dlf_pkg::reg_idx_t'(paddr[2]))
                dlf_pkg::REG_FULL_SCALE: full_scale_reg <= pwdata[7:0];
                dlf_pkg::REG_MIN_MUL:    min_mul_reg    <= pwdata[15:0];
                default:                 full_scale_reg <= full_scale_reg;
            endcase
        end
    end

    always_comb
    begin
        case (dlf_pkg::reg_idx_t'(paddr[2]))
            dlf_pkg::REG_FULL_SCALE: prdata = {24'd0, full_scale_reg};
            dlf_pkg::REG_MIN_MUL:    prdata = {16'd0, min_mul_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    assign full_scale = (full_scale_reg == 8'd0) ? 8'd1 : full_scale_reg;

    // front stage
    dlf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (req_valid),
        .in_ready      (sq_ready[0]),
        .light_level   (light_level),
        .view_distance (view_distance),
        .out_valid     (sq_valid[0]),
        .out_ready     (sq_ready[1]),
        .out_data      (sq_data[0])
    );

    assign req_stall = !sq_ready[0];

    // square root stages
    for (genvar k = 0; k < dlf_pkg::SQ_STAGES; k++)
    begin : g_sqrt
        dlf_sqrt_stage u_sqrt (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[k]),
            .in_ready  (sq_ready[k + 1]),
            .in_data   (sq_data[k]),
            .out_valid (sq_valid[k + 1]),
            .out_ready (sq_ready[k + 2]),
            .out_data  (sq_data[k + 1])
        );
    end

    assign sq_ready[dlf_pkg::SQ_STAGES + 1] = sc_ready;

    dlf_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid[dlf_pkg::SQ_STAGES]),
        .in_ready  (sc_ready),
        .in_data   (sq_data[dlf_pkg::SQ_STAGES]),
        .out_valid (sc_valid),
        .out_ready (dv_ready[0]),
        .bright    (bright)
    );

    // divider setup: saturate when the quotient needs more than 16 bits
    always_comb
    begin
        dv_data[0].rem = {1'b0, bright[15:9]};
        dv_data[0].quo = 16'd0;
        dv_data[0].num = {bright[8:0], 7'd0};
        dv_data[0].sat = ({1'b0, bright[15:9]} >= full_scale);
    end

    assign dv_valid[0] = sc_valid;

    for (genvar k = 0; k < dlf_pkg::DIV_STAGES; k++)
    begin : g_div
        dlf_div_stage u_div (
            .clk        (clk),
            .rst_n      (rst_n),
            .full_scale (full_scale),
            .in_valid   (dv_valid[k]),
            .in_ready   (dv_ready[k]),
            .in_data    (dv_data[k]),
            .out_valid  (dv_valid[k + 1]),
            .out_ready  ((k == dlf_pkg::DIV_STAGES - 1) ? out_ready : dv_ready[k + 1]),
            .out_data   (dv_data[k + 1])
        );
    end

    // output register
    always_comb
    begin
        out_mul_next = dv_data[dlf_pkg::DIV_STAGES].sat ? 16'hFFFF
                                                          : dv_data[dlf_pkg::DIV_STAGES].quo;
        if (out_mul_next < min_mul_reg)
        begin
            out_mul_next = min_mul_reg;
        end
    end

    assign out_ready = !out_valid_reg || !rsp_stall;
    assign dv_ready[dlf_pkg::DIV_STAGES] = out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= dv_valid[dlf_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && dv_valid[dlf_pkg::DIV_STAGES])
        begin
            out_mul_reg <= out_mul_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign light_mul = out_mul_reg;

    a_min_floor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (light_mul >= min_mul_reg))
        else $error("response below minimum multiplier");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("request stalled while output is free");

    a_sat_top: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid[dlf_pkg::DIV_STAGES] && dv_data[dlf_pkg::DIV_STAGES].sat && out_ready)
        |=> (rsp_valid && (light_mul == 16'hFFFF)))
        else $error("saturated quotient not at full scale");

endmodule

[verif/tb_distance_light_falloff.sv]
// tb_distance_light_falloff: self-checking testbench for the distance light falloff block
// predicts each light_mul from the request fields and the register values written over apb
// depends on dlf_pkg and the distance_light_falloff rtl only
`timescale 1ns / 100ps

module tb_distance_light_falloff;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [15:0] light_level = '0;
    logic [23:0] view_distance = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [15:0] light_mul;

    logic [7:0]  full_scale_shadow = 8'd255;
    logic [15:0] min_mul_shadow = '0;
    logic [15:0] light_mul_due[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          gap_enable = 1'b0;
    bit          stall_enable = 1'b0;
    logic        hold_active = 1'b0;
    int          burst_left = 0;

    distance_light_falloff DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .light_level(light_level),
        .view_distance(view_distance),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .light_mul(light_mul)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] calc_light_mul(input logic [15:0] level,
                                                   input logic [23:0] vdist);
        longint lvl;
        longint off;
        longint x;
        longint rad;
        longint root;
        longint trial;
        longint dim;
        longint b;
        longint lo;
        longint hi;
        longint fs;
        longint mul;
        lvl = (level > 16'd255) ? 64'd255 : longint'(level);
        off = (lvl * 256 + 127) / 255;
        x = (longint'(vdist) > off) ? longint'(vdist) - off : 64'd0;
        rad = x << 8;
        root = 0;
        for (int i = 15; i >= 0; i--)
        begin
            trial = root | (longint'(1) << i);
            if (trial * trial <= rad)
                root = trial;
        end
        dim = root * (4080 - 13 * lvl) / 255;
        b = 65280 - dim;
        lo = lvl * 256 / 5;
        hi = lvl * 256;
        if (b < lo)
            b = lo;
        if (b > hi)
            b = hi;
        fs = (full_scale_shadow == 8'd0) ? 64'd1 : longint'(full_scale_shadow);
        mul = b * 128 / fs;
        if (mul > 65535)
            mul = 65535;
        if (mul < longint'(min_mul_shadow))
            mul = longint'(min_mul_shadow);
        return mul[15:0];
    endfunction

    // response check first, then record the request taken at this edge
    always @(posedge clk)
    begin
        logic [15:0] due;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (light_mul_due.size() == 0)
            begin
                $error("light_mul response with no request outstanding: actual %0d", light_mul);
                error_count++;
            end
            else
            begin
                due = light_mul_due.pop_front();
                if (light_mul !== due)
                begin
                    $error("light_mul mismatch: expected %0d actual %0d", due, light_mul);
                    error_count++;
                end
            end
        end
        if (rst_n && req_valid && !req_stall)
            light_mul_due.push_back(calc_light_mul(light_level, view_distance));
    end

    // receiver stall: long hold-off or short random bursts
    always @(posedge clk)
    begin
        if (hold_active)
            rsp_stall <= 1'b1;
        else if (burst_left > 0)
        begin
            rsp_stall <= 1'b1;
            burst_left <= burst_left - 1;
        end
        else if (stall_enable && $urandom_range(0, 5) == 0)
        begin
            rsp_stall <= 1'b1;
            burst_left <= $urandom_range(0, 2);
        end
        else
            rsp_stall <= 1'b0;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("distance_light_falloff verification failed");
        $finish;
    end

    task automatic apb_read(input dlf_pkg::reg_idx_t idx, output logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(input dlf_pkg::reg_idx_t idx, input logic [31:0] want);
        logic [31:0] got;
        apb_read(idx, got);
        if (got !== want)
        begin
            $error("%s readback mismatch: expected %0d actual %0d", idx.name(), want, got);
            error_count++;
        end
    endtask

    task automatic set_register(input dlf_pkg::reg_idx_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        if (idx == dlf_pkg::REG_FULL_SCALE)
            full_scale_shadow = value[7:0];
        else
            min_mul_shadow = value[15:0];
        check_register(idx, (idx == dlf_pkg::REG_FULL_SCALE) ? {24'd0, value[7:0]}
                                                             : {16'd0, value[15:0]});
    endtask

    task automatic set_config(input logic [7:0] full_scale, input logic [15:0] min_mul);
        set_register(dlf_pkg::REG_FULL_SCALE, {24'd0, full_scale});
        set_register(dlf_pkg::REG_MIN_MUL, {16'd0, min_mul});
    endtask

    task automatic send_request(input logic [15:0] level, input logic [23:0] vdist);
        req_valid <= 1'b1;
        light_level <= level;
        view_distance <= vdist;
        do
            @(posedge clk);
        while (req_stall);
        if (gap_enable && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_random_request();
        logic [15:0] level;
        logic [23:0] vdist;
        case ($urandom_range(0, 9))
            0, 1: level = 16'($urandom_range(0, 65535));
            2: level = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'd255;
            default: level = 16'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 9))
            0, 1: vdist = 24'($urandom_range(0, 1000));
            2, 3: vdist = 24'($urandom);
            default: vdist = 24'($urandom_range(0, 70000));
        endcase
        send_request(level, vdist);
    endtask

    // wait for every outstanding response, then idle before the next test
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (light_mul_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic test_reset_values();
        check_register(dlf_pkg::REG_FULL_SCALE, 32'd255);
        check_register(dlf_pkg::REG_MIN_MUL, 32'd0);
    endtask

    task automatic test_directed_corners();
        send_request(16'd0, 24'd0);
        send_request(16'd0, 24'hFFFFFF);
        send_request(16'd255, 24'd0);
        send_request(16'd255, 24'd255);
        send_request(16'd255, 24'd256);
        send_request(16'd255, 24'd257);
        send_request(16'd256, 24'd1000);
        send_request(16'hFFFF, 24'hFFFFFF);
        send_request(16'hFFFF, 24'd0);
        send_request(16'd128, 24'd0);
        send_request(16'd128, 24'd129);
        send_request(16'd128, 24'd20000);
        send_request(16'd1, 24'd1);
        send_request(16'd1, 24'd2);
        send_request(16'd200, 24'd65000);
        send_request(16'h8000, 24'd40000);
        send_request(16'd50, 24'h555555);
        send_request(16'd170, 24'hAAAAAA);
        drain();
    endtask

    // full scale of one saturates a bright request, zero acts as one
    task automatic test_full_scale_extremes();
        set_config(8'd1, 16'd0);
        send_request(16'd255, 24'd0);
        send_request(16'd1, 24'd0);
        send_request(16'd0, 24'd5);
        drain();
        set_config(8'd0, 16'd0);
        send_request(16'd255, 24'd0);
        send_request(16'd0, 24'd0);
        drain();
    endtask

    task automatic test_min_multiplier();
        set_config(8'd255, 16'd32768);
        send_request(16'd0, 24'd0);
        send_request(16'd255, 24'd0);
        drain();
        set_config(8'd128, 16'hFFFF);
        send_request(16'd255, 24'd100);
        send_request(16'd10, 24'hFFFFFF);
        drain();
    endtask

    task automatic test_random_phases();
        logic [7:0]  fs;
        logic [15:0] mm;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin fs = 8'd1; mm = 16'd0; end
                1: begin fs = 8'd255; mm = 16'd32768; end
                2: begin fs = 8'd0; mm = 16'($urandom_range(0, 32768)); end
                default:
                begin
                    fs = 8'($urandom_range(1, 255));
                    mm = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(0, 32768));
                end
            endcase
            set_config(fs, mm);
            gap_enable = (phase % 3 != 2);
            stall_enable = (phase % 3 != 1);
            repeat (150) send_random_request();
            drain();
        end
    endtask

    task automatic test_backpressure();
        set_config(8'd255, 16'd0);
        gap_enable = 1'b0;
        stall_enable = 1'b0;
        fork
            begin
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active <= 1'b0;
            end
        join_none
        repeat (60) send_random_request();
        drain();
    endtask

    task automatic test_full_rate_tail();
        set_config(8'($urandom_range(1, 255)), 16'($urandom_range(0, 4096)));
        gap_enable = 1'b0;
        stall_enable = 1'b0;
        repeat (300) send_random_request();
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed_corners();
        test_full_scale_extremes();
        test_min_multiplier();
        test_random_phases();
        test_backpressure();
        test_full_rate_tail();
        if (error_count == 0)
            $display("distance_light_falloff verification clean");
        else
            $display("distance_light_falloff verification failed");
        $finish;
    end

endmodule
